FILE: hdl/wsq_pkg.sv
package wsq_pkg;

  // widths of the fixed port fields
  localparam int unsigned CpuFieldW    = 3;
  localparam int unsigned HandleFieldW = 32;
  localparam int unsigned StatusW      = 3;

  // request kinds
  localparam logic KIND_PUSH    = 1'b0;
  localparam logic KIND_TRYWORK = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_PUSHED = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL   = 3'd1;
  localparam logic [StatusW-1:0] ST_POPPED = 3'd2;
  localparam logic [StatusW-1:0] ST_STOLEN = 3'd3;
  localparam logic [StatusW-1:0] ST_NOWORK = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;  // capture the input beat
    logic wr_push;   // write handle at own head, report pushed
    logic wr_full;   // report queue full
    logic pop;       // pop own head, start slot read
    logic pick;      // latch the chosen victim
    logic nowork;    // report no work
    logic steal;     // take victim tail, start slot read
    logic take;      // load slot read data into the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic kind;
    logic own_full;
    logic own_nonempty;
    logic victim_found;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/wsq_ram.sv
module wsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read that holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/wsq_ctrl.sv
module wsq_ctrl
  import wsq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_STEAL = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.kind == KIND_PUSH) begin
          if (sts_i.out_free) begin
            cmd_o.wr_full = sts_i.own_full;
            cmd_o.wr_push = !sts_i.own_full;
            state_d       = S_IDLE;
          end
        end else if (sts_i.own_nonempty) begin
          cmd_o.pop = 1'b1;
          state_d   = S_READ;
        end else if (sts_i.victim_found) begin
          cmd_o.pick = 1'b1;
          state_d    = S_STEAL;
        end else if (sts_i.out_free) begin
          cmd_o.nowork = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_STEAL: begin
        cmd_o.steal = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.take = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOOK)
    else $error("accepted beat did not move to look");

  a_steal_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEAL |=> state_q == S_READ)
    else $error("steal did not move to slot read");

  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && $past(state_q) != S_READ) |->
      ($past(cmd_o.pop) || $past(cmd_o.steal)))
    else $error("slot read entered without pop or steal");
`endif

endmodule

FILE: hdl/wsq_dp.sv
module wsq_dp
  import wsq_pkg::*;
#(
  parameter int unsigned NUM_CPUS    = 8,
  parameter int unsigned RING_SLOTS  = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    kind_i,
  input  logic [CpuFieldW-1:0]    cpu_i,
  input  logic [HandleFieldW-1:0] work_handle_i,
  input  logic [CpuFieldW-1:0]    victim_start_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatusW-1:0]      status_o,
  output logic [HandleFieldW-1:0] got_handle_o,
  output logic [CpuFieldW-1:0]    source_cpu_o
);

  localparam int unsigned CW    = $clog2(NUM_CPUS);
  localparam int unsigned CTW   = $clog2(2 * RING_SLOTS);
  localparam int unsigned SW    = $clog2(RING_SLOTS);
  localparam int unsigned DEPTH = NUM_CPUS * RING_SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned InVals = 2 ** CpuFieldW;

  localparam logic [CTW-1:0] CNT_MAX = CTW'(2 * RING_SLOTS - 1);
  localparam logic [CTW-1:0] RS_C    = CTW'(RING_SLOTS);
  localparam logic [CTW:0]   MOD_W   = (CTW + 1)'(2 * RING_SLOTS);
  localparam logic [CTW:0]   RS_W    = (CTW + 1)'(RING_SLOTS);
  localparam logic [CW:0]    NUM_W   = (CW + 1)'(NUM_CPUS);

  // request registers
  logic                   kind_q;
  logic [CW-1:0]          me_q;
  logic [CW-1:0]          start_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [CW-1:0]          victim_q;
  logic [CW-1:0]          src_q;
  logic                   stolen_q;

  // ring counters
  logic [CTW-1:0] head_q [NUM_CPUS];
  logic [CTW-1:0] tail_q [NUM_CPUS];

  // result register
  logic                    out_valid_q;
  logic [StatusW-1:0]      status_q;
  logic [HandleFieldW-1:0] got_q;
  logic [CpuFieldW-1:0]    src_out_q;

  logic [CW-1:0]          red_tab [InVals];
  logic [CW-1:0]          sel;
  logic [CTW-1:0]         head_sel, tail_sel, head_inc, head_dec, tail_inc, cnt_addr;
  logic [CTW:0]           occ;
  logic [SW-1:0]          slot_low;
  logic [AW-1:0]          slot_addr;
  logic [NUM_CPUS-1:0]    cand, rot;
  logic [2*NUM_CPUS-1:0]  rot_w;
  logic [CW-1:0]          off, pick;
  logic [CW:0]            vsum;
  logic                   found;
  logic                   out_free;
  logic                   load_out;
  logic [HANDLE_BITS-1:0] rdata;

  // processor number reduction, worked out at elaboration
  for (genvar g = 0; g < InVals; g++) begin : g_red
    assign red_tab[g] = CW'(g % NUM_CPUS);
  end

  // capture the request beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= 1'b0;
      me_q     <= '0;
      start_q  <= '0;
      hnd_q    <= '0;
      victim_q <= '0;
      src_q    <= '0;
      stolen_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        kind_q  <= kind_i;
        me_q    <= red_tab[cpu_i];
        start_q <= red_tab[victim_start_i];
        hnd_q   <= HANDLE_BITS'(work_handle_i);
      end
      if (cmd_i.pick) begin
        victim_q <= pick;
      end
      if (cmd_i.pop) begin
        src_q    <= me_q;
        stolen_q <= 1'b0;
      end
      if (cmd_i.steal) begin
        src_q    <= victim_q;
        stolen_q <= 1'b1;
      end
    end
  end

  // counter read for own queue, or for the victim while stealing
  assign sel      = cmd_i.steal ? victim_q : me_q;
  assign head_sel = head_q[sel];
  assign tail_sel = tail_q[sel];
  assign head_inc = (head_sel == CNT_MAX) ? '0 : head_sel + 1'b1;
  assign head_dec = (head_sel == '0) ? CNT_MAX : head_sel - 1'b1;
  assign tail_inc = (tail_sel == CNT_MAX) ? '0 : tail_sel + 1'b1;

  // occupancy is head minus tail modulo twice the ring size
  assign occ = (head_sel >= tail_sel) ? ({1'b0, head_sel} - {1'b0, tail_sel})
                                      : ({1'b0, head_sel} + (MOD_W - {1'b0, tail_sel}));

  // slot address: queue base plus counter modulo ring size
  always_comb begin
    cnt_addr = tail_sel;
    if (cmd_i.pop) begin
      cnt_addr = head_dec;
    end else if (cmd_i.wr_push) begin
      cnt_addr = head_sel;
    end
  end

  assign slot_low  = (cnt_addr >= RS_C) ? SW'(cnt_addr - RS_C) : SW'(cnt_addr);
  assign slot_addr = AW'(sel) * AW'(RING_SLOTS) + AW'(slot_low);

  // rotating victim pick over non-empty queues, requester skipped
  always_comb begin
    cand = '0;
    for (int j = 0; j < NUM_CPUS; j++) begin
      cand[j] = (head_q[j] != tail_q[j]) && (CW'(j) != me_q);
    end
    rot_w = {cand, cand} >> start_q;
    rot   = rot_w[NUM_CPUS-1:0];
    off   = '0;
    for (int j = NUM_CPUS - 1; j >= 0; j--) begin
      if (rot[j]) begin
        off = CW'(j);
      end
    end
    found = |rot;
    vsum  = {1'b0, start_q} + {1'b0, off};
    pick  = (vsum >= NUM_W) ? CW'(vsum - NUM_W) : CW'(vsum);
  end

  // ring counter update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_CPUS; j++) begin
        head_q[j] <= '0;
        tail_q[j] <= '0;
      end
    end else begin
      if (cmd_i.wr_push) begin
        head_q[sel] <= head_inc;
      end
      if (cmd_i.pop) begin
        head_q[sel] <= head_dec;
      end
      if (cmd_i.steal) begin
        tail_q[sel] <= tail_inc;
      end
    end
  end

  // handle store
  wsq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_push),
    .re_i    (cmd_i.pop || cmd_i.steal),
    .addr_i  (slot_addr),
    .wdata_i (hnd_q),
    .rdata_o (rdata)
  );

  // result register, free when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = cmd_i.wr_push || cmd_i.wr_full || cmd_i.nowork || cmd_i.take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_push || cmd_i.wr_full) begin
      status_q  <= cmd_i.wr_push ? ST_PUSHED : ST_FULL;
      got_q     <= '0;
      src_out_q <= CpuFieldW'(me_q);
    end else if (cmd_i.nowork) begin
      status_q  <= ST_NOWORK;
      got_q     <= '0;
      src_out_q <= '0;
    end else if (cmd_i.take) begin
      status_q  <= stolen_q ? ST_STOLEN : ST_POPPED;
      got_q     <= HandleFieldW'(rdata);
      src_out_q <= CpuFieldW'(src_q);
    end
  end

  assign sts_o.kind         = kind_q;
  assign sts_o.own_full     = (occ == RS_W);
  assign sts_o.own_nonempty = (occ != '0);
  assign sts_o.victim_found = found;
  assign sts_o.out_free     = out_free;

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign got_handle_o = got_q;
  assign source_cpu_o = src_out_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= RS_W)
    else $error("ring occupancy above ring size");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result loaded over an unread result");

  a_victim_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick |-> (found && pick != me_q && cand[pick]))
    else $error("victim pick is the requester or empty");
`endif

endmodule

FILE: hdl/work_stealing_queue_engine.sv
// channel   valid        stall        payload
// request   in_valid_i   in_stall_o   kind_i cpu_i work_handle_i victim_start_i
// result    out_valid_o  out_stall_i  status_o got_handle_o source_cpu_o
//
// one request at a time; push, full and no-work finish in the look state,
// own pop goes look then slot read, steal goes look, steal, slot read
// a finished result sits in an output register while the next request is
// taken; a request that needs that register waits while it is still full
// reset clears all head and tail counters; slot memory needs no clearing
module work_stealing_queue_engine
  import wsq_pkg::*;
#(
  parameter int unsigned NUM_CPUS    = 8,
  parameter int unsigned RING_SLOTS  = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [CpuFieldW-1:0]    cpu_i,
  input  logic [HandleFieldW-1:0] work_handle_i,
  input  logic [CpuFieldW-1:0]    victim_start_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatusW-1:0]      status_o,
  output logic [HandleFieldW-1:0] got_handle_o,
  output logic [CpuFieldW-1:0]    source_cpu_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  wsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, slot memory and result register
  wsq_dp #(
    .NUM_CPUS    (NUM_CPUS),
    .RING_SLOTS  (RING_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .cpu_i          (cpu_i),
    .work_handle_i  (work_handle_i),
    .victim_start_i (victim_start_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .got_handle_o   (got_handle_o),
    .source_cpu_o   (source_cpu_o)
  );

endmodule
